>>> rtl/efl_pkg.sv
// efl_pkg: constants and types for the heap allocator
// no dependencies
package efl_pkg;
   localparam int unsigned HeapBytes = 65536;
   localparam int unsigned ChunkBytes = 4096;
   localparam int unsigned AlignBytes = 16;
   localparam int unsigned HeapLimit = (HeapBytes < 65536) ? HeapBytes : 65536;
   localparam int unsigned HeapWords = HeapLimit / 4;
   localparam int unsigned AddrW = $clog2(HeapWords);
   localparam int unsigned MinBlock = 24;
   localparam int unsigned ChunkSize =
      ((ChunkBytes / 4 * 4) + AlignBytes - 1) / AlignBytes * AlignBytes;
   localparam int unsigned AlignMask = AlignBytes - 1;

   localparam logic [1:0] StDone = 2'd0;
   localparam logic [1:0] StZero = 2'd1;
   localparam logic [1:0] StFull = 2'd2;
   localparam logic ActAlloc = 1'b0;
   localparam logic ActFree = 1'b1;
endpackage

>>> rtl/explicit_free_list_heap_allocator.sv
// explicit_free_list_heap_allocator: boundary-tag heap with explicit LIFO free list
// depends on efl_pkg
//
// usage:
//   req channel carries one beat per request: req_action selects allocate
//   or free, req_request_bytes is the payload size for allocate,
//   req_block_offset the payload offset for free.
//   rsp channel returns one beat per request: rsp_payload_offset (0 for
//   null or free) and rsp_status (done, zero-size, heap exhausted).
//   each request runs as a microcoded sequence of single-word reads and
//   writes on one 32-bit heap memory with a registered read.
//   one memory access per cycle sets the rate; an allocate walks the free
//   list first-fit and grows the heap when no free block fits.
//   the block takes one request at a time; req_stall stays high while a
//   request is in work or its response waits.
//   after reset the block clears the heap memory one word a cycle
//   (HeapWords words, 16384 by default) and writes the prologue, the
//   epilogue and one free chunk before it takes the first request.
//   a stalled response holds its payload until rsp_stall falls.
module explicit_free_list_heap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_request_bytes,
   input  logic [15:0] req_block_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_payload_offset,
   output logic [1:0]  rsp_status
);
   import efl_pkg::*;

   // sequencer states, one-hot
   typedef enum logic [23:0] {
      S_CLEAR  = 24'h000001,
      S_IDLE   = 24'h000002,
      S_DEC    = 24'h000004,
      S_FFRD   = 24'h000008,
      S_FFCHK  = 24'h000010,
      S_GROW   = 24'h000020,
      S_FREEA  = 24'h000040,
      S_FREEB  = 24'h000080,
      S_MRG0   = 24'h000100,
      S_MRG1   = 24'h000200,
      S_MRG2   = 24'h000400,
      S_MRGC   = 24'h000800,
      S_UNL0   = 24'h001000,
      S_UNL1   = 24'h002000,
      S_UNLW   = 24'h004000,
      S_MRGW   = 24'h008000,
      S_PUSH   = 24'h010000,
      S_CARVE0 = 24'h020000,
      S_CARVE1 = 24'h040000,
      S_RESP   = 24'h080000,
      S_WRQ    = 24'h100000,
      S_RDW    = 24'h200000,
      S_RDW2   = 24'h400000,
      S_INIT   = 24'h800000
   } state_type;

   // continuation after merge/unlink/write sequences
   typedef enum logic [3:0] {
      K_NONE, K_MRG_NEXT, K_MRG_PREV, K_MRG_BOTH2, K_MRG_W, K_CARVE_SPLIT,
      K_CARVE_W, K_RESP, K_FREE_M, K_GROW_M, K_INIT_DONE, K_PUSH_DONE
   } cont_type;

   logic [31:0] mem [HeapWords];
   logic [31:0] rdata_ff;

   state_type   state_ff, state_in;
   cont_type    cont_ff, cont_in;
   logic [AddrW:0] clr_ff, clr_in;

   logic        act_ff, act_in;
   logic [16:0] req_ff, req_in;
   logic [16:0] off_ff, off_in;
   logic [16:0] asize_ff, asize_in;
   logic [16:0] bp_ff, bp_in;
   logic [16:0] p_ff, p_in;
   logic [16:0] size_ff, size_in;
   logic [16:0] csize_ff, csize_in;
   logic [16:0] nsize_ff, nsize_in;
   logic [16:0] psize_ff, psize_in;
   logic [16:0] head_ff, head_in;
   logic [16:0] brk_ff, brk_in;
   logic [16:0] ul_ff, ul_in;
   logic [16:0] ulp_ff, ulp_in;
   logic [31:0] hdr_ff, hdr_in;
   logic [16:0] walk_ff, walk_in;
   logic [4:0]  step_ff, step_in;
   logic        pa_ff, pa_in;
   logic [15:0] res_ff, res_in;
   logic [1:0]  stat_ff, stat_in;
   logic        ovld_ff, ovld_in;

   // write queue: up to 4 pending writes
   logic [16:0] wa_ff [4], wa_in [4];
   logic [31:0] wd_ff [4], wd_in [4];
   logic [2:0]  wn_ff, wn_in, wi_ff, wi_in;

   logic        we;
   logic [AddrW-1:0] waddr, raddr;
   logic [31:0] wdata;
   logic        re;
   logic [16:0] rbyte;
   logic        rok_ff, rok_in;

   // memory
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   logic [31:0] rd_v;
   assign rd_v = rok_ff ? rdata_ff : 32'd0;

   function automatic logic [16:0] rnd(input logic [16:0] x);
      logic [16:0] t;
      t = x + 17'(AlignMask);
      return t & ~17'(AlignMask);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         ovld_ff  <= 1'b0;
         cont_ff  <= K_NONE;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ovld_ff  <= ovld_in;
         cont_ff  <= cont_in;
      end
      act_ff <= act_in; req_ff <= req_in; off_ff <= off_in; asize_ff <= asize_in;
      bp_ff <= bp_in; p_ff <= p_in; size_ff <= size_in; csize_ff <= csize_in;
      nsize_ff <= nsize_in; psize_ff <= psize_in; head_ff <= head_in;
      brk_ff <= brk_in; ul_ff <= ul_in; ulp_ff <= ulp_in;
      hdr_ff <= hdr_in; walk_ff <= walk_in; step_ff <= step_in;
      pa_ff <= pa_in; res_ff <= res_in; stat_ff <= stat_in;
      wn_ff <= wn_in; wi_ff <= wi_in; rok_ff <= rok_in;
      for (int i = 0; i < 4; i++) begin
         wa_ff[i] <= wa_in[i];
         wd_ff[i] <= wd_in[i];
      end
   end

   assign req_stall = !(state_ff == S_IDLE) || ovld_ff;
   assign rsp_valid = ovld_ff;
   assign rsp_payload_offset = res_ff;
   assign rsp_status = stat_ff;

   always_comb begin
      logic [16:0] sz, nxt, t;
      logic [31:0] h;
      logic [16:0] rest;
      state_in = state_ff; cont_in = cont_ff; clr_in = clr_ff;
      act_in = act_ff; req_in = req_ff; off_in = off_ff; asize_in = asize_ff;
      bp_in = bp_ff; p_in = p_ff; size_in = size_ff; csize_in = csize_ff;
      nsize_in = nsize_ff; psize_in = psize_ff; head_in = head_ff;
      brk_in = brk_ff; ul_in = ul_ff; ulp_in = ulp_ff;
      hdr_in = hdr_ff; walk_in = walk_ff; step_in = step_ff;
      pa_in = pa_ff; res_in = res_ff; stat_in = stat_ff;
      ovld_in = ovld_ff && rsp_stall;
      wn_in = wn_ff; wi_in = wi_ff;
      for (int i = 0; i < 4; i++) begin
         wa_in[i] = wa_ff[i];
         wd_in[i] = wd_ff[i];
      end
      we = 1'b0; waddr = '0; wdata = '0; re = 1'b0; rbyte = '0; rok_in = rok_ff;
      sz = '0; nxt = '0; t = '0; h = '0; rest = '0;

      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            waddr = clr_ff[AddrW-1:0];
            wdata = '0;
            if (clr_ff == (AddrW+1)'(HeapWords - 1)) begin
               state_in = S_INIT;
               step_in = '0;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_INIT: begin
            // prologue, epilogue, then grow by the first chunk
            case (step_ff)
               5'd0: begin we = 1'b1; waddr = AddrW'(1); wdata = 32'd9; end
               5'd1: begin we = 1'b1; waddr = AddrW'(2); wdata = 32'd9; end
               default: begin we = 1'b1; waddr = AddrW'(3); wdata = 32'd1; end
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd2) begin
               brk_in = 17'd16;
               head_in = '0;
               size_in = rnd(17'(ChunkSize));
               cont_in = K_INIT_DONE;
               state_in = S_GROW;
            end
         end
         S_IDLE: begin
            if (req_valid && !ovld_ff) begin
               act_in = req_action;
               req_in = {1'b0, req_request_bytes};
               off_in = {1'b0, req_block_offset};
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            res_in = '0;
            stat_in = StDone;
            if (act_ff == ActAlloc) begin
               if (req_ff == '0) begin
                  stat_in = StZero;
                  state_in = S_RESP;
               end else begin
                  t = req_ff + 17'd8;
                  asize_in = (t <= 17'(MinBlock)) ? 17'(MinBlock) : rnd(t);
                  p_in = head_ff;
                  walk_in = '0;
                  state_in = S_FFRD;
               end
            end else begin
               // read header of block to free
               rbyte = off_ff - 17'd4;
               re = 1'b1;
               raddr = rbyte[AddrW+1:2];
               rok_in = (off_ff >= 17'd4) && (rbyte < 17'(HeapLimit));
               state_in = S_FREEA;
            end
         end
         S_FFRD: begin
            if (p_ff == '0 || walk_ff >= 17'(HeapWords)) begin
               t = (asize_ff > 17'(ChunkBytes)) ? asize_ff : 17'(ChunkBytes);
               size_in = rnd(t & ~17'd3);
               cont_in = K_GROW_M;
               state_in = S_GROW;
            end else begin
               rbyte = p_ff - 17'd4;
               re = 1'b1;
               raddr = rbyte[AddrW+1:2];
               rok_in = (p_ff >= 17'd4) && (rbyte < 17'(HeapLimit));
               step_in = '0;
               state_in = S_FFCHK;
            end
         end
         S_FFCHK: begin
            if (step_ff == '0) begin
               sz = rd_v[16:0] & ~17'd7;
               if (rd_v[31:17] == '0 && asize_ff <= sz) begin
                  bp_in = p_ff;
                  csize_in = sz;
                  state_in = S_CARVE0;
                  step_in = '0;
               end else if (rd_v[31:17] != '0 && asize_ff <= 17'h1FFF8) begin
                  bp_in = p_ff;
                  csize_in = sz;
                  state_in = S_CARVE0;
                  step_in = '0;
               end else begin
                  re = 1'b1;
                  raddr = p_ff[AddrW+1:2];
                  rok_in = p_ff < 17'(HeapLimit);
                  step_in = 5'd1;
               end
            end else begin
               p_in = {1'b0, rd_v[15:0]};
               walk_in = walk_ff + 1'b1;
               state_in = S_FFRD;
            end
         end
         S_GROW: begin
            bp_in = brk_ff;
            if (brk_ff > 17'(HeapLimit) || size_ff > 17'(HeapLimit) - brk_ff) begin
               if (cont_ff == K_INIT_DONE) begin
                  clr_in[AddrW] = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  stat_in = StFull;
                  state_in = S_RESP;
               end
            end else begin
               wa_in[0] = brk_ff - 17'd4; wd_in[0] = {15'd0, size_ff};
               wa_in[1] = brk_ff + size_ff - 17'd8; wd_in[1] = {15'd0, size_ff};
               wa_in[2] = brk_ff + size_ff - 17'd4; wd_in[2] = 32'd1;
               wn_in = 3'd3; wi_in = '0;
               brk_in = brk_ff + size_ff;
               state_in = S_WRQ;
               cont_in = (cont_ff == K_INIT_DONE) ? K_INIT_DONE : K_GROW_M;
               step_in = 5'd1; // marks grow path into merge
            end
         end
         S_FREEA: begin
            h = rd_v;
            hdr_in = h;
            sz = h[16:0] & ~17'd7;
            if (off_ff >= 17'd16 && off_ff[2:0] == '0 && off_ff < brk_ff && h[0] &&
                h[31:17] == '0 && sz >= 17'(MinBlock) && sz <= brk_ff - off_ff) begin
               size_in = sz;
               rbyte = off_ff + sz - 17'd8;
               re = 1'b1;
               raddr = rbyte[AddrW+1:2];
               rok_in = rbyte < 17'(HeapLimit);
               state_in = S_FREEB;
            end else begin
               state_in = S_RESP;
            end
         end
         S_FREEB: begin
            if (rd_v == hdr_ff) begin
               wa_in[0] = off_ff - 17'd4; wd_in[0] = {15'd0, size_ff};
               wa_in[1] = off_ff + size_ff - 17'd8; wd_in[1] = {15'd0, size_ff};
               wn_in = 3'd2; wi_in = '0;
               bp_in = off_ff;
               cont_in = K_FREE_M;
               state_in = S_WRQ;
            end else begin
               state_in = S_RESP;
            end
         end
         S_WRQ: begin
            // drain pending writes, one per cycle
            if (wi_ff < wn_ff) begin
               we = wa_ff[wi_ff[1:0]] < 17'(HeapLimit);
               waddr = wa_ff[wi_ff[1:0]][AddrW+1:2];
               wdata = wd_ff[wi_ff[1:0]];
               wi_in = wi_ff + 1'b1;
            end else begin
               case (cont_ff)
                  K_FREE_M, K_GROW_M, K_INIT_DONE: state_in = S_MRG0;
                  K_MRG_NEXT, K_MRG_PREV, K_MRG_BOTH2, K_MRG_W: state_in = S_MRGW;
                  K_CARVE_SPLIT: state_in = S_PUSH;
                  K_CARVE_W, K_RESP: state_in = S_RESP;
                  K_PUSH_DONE: state_in = S_PUSH;
                  default: state_in = S_RESP;
               endcase
               if (cont_ff == K_MRG_NEXT || cont_ff == K_MRG_PREV ||
                   cont_ff == K_MRG_BOTH2 || cont_ff == K_MRG_W) begin
                  state_in = S_MRGC;
               end
               if (cont_ff == K_PUSH_DONE) begin
                  // push finished: continue after merge or carve
                  state_in = S_RDW2;
               end
            end
         end
         S_MRG0: begin
            // read footer of prev block
            rbyte = bp_ff - 17'd8;
            re = 1'b1;
            raddr = rbyte[AddrW+1:2];
            rok_in = (bp_ff >= 17'd8) && (rbyte < 17'(HeapLimit));
            state_in = S_MRG1;
            step_in = '0;
         end
         S_MRG1: begin
            if (step_ff == '0) begin
               pa_in = rd_v[0];
               psize_in = rd_v[16:0] & ~17'd7;
               rbyte = bp_ff - 17'd4;
               re = 1'b1;
               raddr = rbyte[AddrW+1:2];
               rok_in = (bp_ff >= 17'd4) && (rbyte < 17'(HeapLimit));
               step_in = 5'd1;
            end else begin
               size_in = rd_v[16:0] & ~17'd7;
               nxt = bp_ff + (rd_v[16:0] & ~17'd7);
               p_in = nxt;
               rbyte = nxt - 17'd4;
               re = 1'b1;
               raddr = rbyte[AddrW+1:2];
               rok_in = (nxt >= 17'd4) && (rbyte < 17'(HeapLimit));
               state_in = S_MRG2;
            end
         end
         S_MRG2: begin
            nsize_in = rd_v[16:0] & ~17'd7;
            // p_ff holds next, bp_ff - psize is prev
            if (pa_ff && rd_v[0]) begin
               state_in = S_MRGW;
               cont_in = K_MRG_W;
            end else if (pa_ff && !rd_v[0]) begin
               ul_in = p_ff;
               cont_in = K_MRG_NEXT;
               state_in = S_UNL0;
            end else begin
               ul_in = bp_ff - psize_ff;
               cont_in = rd_v[0] ? K_MRG_PREV : K_MRG_BOTH2;
               state_in = S_UNL0;
            end
         end
         S_UNL0: begin
            rbyte = ul_ff + 17'd4;
            re = 1'b1;
            raddr = rbyte[AddrW+1:2];
            rok_in = rbyte < 17'(HeapLimit);
            step_in = '0;
            state_in = S_UNL1;
         end
         S_UNL1: begin
            if (step_ff == '0) begin
               ulp_in = {1'b0, rd_v[15:0]};
               re = 1'b1;
               raddr = ul_ff[AddrW+1:2];
               rok_in = ul_ff < 17'(HeapLimit);
               step_in = 5'd1;
            end else begin
               wn_in = '0;
               if (ulp_ff == '0) begin
                  head_in = {1'b0, rd_v[15:0]};
               end else begin
                  wa_in[0] = ulp_ff; wd_in[0] = {16'd0, rd_v[15:0]};
                  wn_in = 3'd1;
               end
               if (rd_v[15:0] != '0) begin
                  wa_in[wn_in[1:0]] = {1'b0, rd_v[15:0]} + 17'd4;
                  wd_in[wn_in[1:0]] = {15'd0, ulp_ff};
                  wn_in = wn_in + 1'b1;
               end
               wi_in = '0;
               state_in = S_WRQ;
            end
         end
         S_MRGC: begin
            // unlink finished; decide what follows
            case (cont_ff)
               K_MRG_NEXT: begin
                  size_in = size_ff + nsize_ff;
                  state_in = S_MRGW;
               end
               K_MRG_PREV: begin
                  size_in = size_ff + psize_ff;
                  bp_in = bp_ff - psize_ff;
                  state_in = S_MRGW;
               end
               K_MRG_BOTH2: begin
                  ul_in = p_ff;
                  cont_in = K_MRG_W;
                  step_in = 5'd2;
                  state_in = S_UNL0;
               end
               K_MRG_W: begin
                  if (step_ff == 5'd2 || pa_ff == 1'b0) begin
                     size_in = size_ff + psize_ff + nsize_ff;
                     bp_in = bp_ff - psize_ff;
                  end
                  state_in = S_MRGW;
               end
               default: state_in = S_MRGW;
            endcase
            cont_in = (cont_ff == K_MRG_BOTH2) ? K_MRG_W : K_NONE;
            if (cont_ff == K_MRG_BOTH2) begin
               state_in = S_UNL0;
            end
         end
         S_MRGW: begin
            wa_in[0] = bp_ff - 17'd4; wd_in[0] = {15'd0, size_ff};
            wa_in[1] = bp_ff + size_ff - 17'd8; wd_in[1] = {15'd0, size_ff};
            wn_in = 3'd2; wi_in = '0;
            p_in = bp_ff;
            cont_in = K_PUSH_DONE;
            step_in = '0;
            state_in = S_RDW;
         end
         S_RDW: begin
            // drain footer/header writes then push p_ff
            if (wi_ff < wn_ff) begin
               we = wa_ff[wi_ff[1:0]] < 17'(HeapLimit);
               waddr = wa_ff[wi_ff[1:0]][AddrW+1:2];
               wdata = wd_ff[wi_ff[1:0]];
               wi_in = wi_ff + 1'b1;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            wa_in[0] = p_ff; wd_in[0] = {15'd0, head_ff};
            wa_in[1] = p_ff + 17'd4; wd_in[1] = '0;
            wn_in = 3'd2;
            if (head_ff != '0) begin
               wa_in[2] = head_ff + 17'd4; wd_in[2] = {15'd0, p_ff};
               wn_in = 3'd3;
            end
            wi_in = '0;
            head_in = p_ff & 17'hFFFF;
            cont_in = K_PUSH_DONE;
            state_in = S_WRQ;
         end
         S_RDW2: begin
            // after a push: merge result in bp_ff, or split remainder done
            if (act_ff == ActFree) begin
               state_in = S_RESP;
            end else if (cont_ff == K_PUSH_DONE && step_ff == 5'd9) begin
               state_in = S_RESP;
            end else if (clr_ff[AddrW] && step_ff == 5'd8) begin
               state_in = S_RESP;
            end else begin
               state_in = S_RESP;
            end
            if (act_ff == ActAlloc && step_ff != 5'd9) begin
               if (walk_ff[16]) begin
                  state_in = S_RESP;
               end else if (res_ff == '0 && stat_ff == StDone && !clr_ff[AddrW]) begin
                  state_in = S_IDLE;
               end else begin
                  // grown block in bp_ff, now carve it
                  csize_in = size_ff;
                  state_in = S_CARVE0;
                  step_in = '0;
               end
            end
            if (!clr_ff[AddrW]) begin
               state_in = S_IDLE; // reset-time grow done
               clr_in[AddrW] = 1'b1;
            end
         end
         S_CARVE0: begin
            // unlink bp then write tags
            ul_in = bp_ff;
            step_in = 5'd9;
            cont_in = K_CARVE_W;
            state_in = S_UNL0;
            walk_in = '0;
         end
         S_CARVE1: begin
            rest = bp_ff + asize_ff;
            res_in = bp_ff[15:0];
            if (csize_ff >= asize_ff && csize_ff - asize_ff >= 17'(MinBlock)) begin
               wa_in[0] = bp_ff - 17'd4; wd_in[0] = {15'd0, asize_ff | 17'd1};
               wa_in[1] = bp_ff + asize_ff - 17'd8; wd_in[1] = {15'd0, asize_ff | 17'd1};
               wa_in[2] = rest - 17'd4; wd_in[2] = {15'd0, csize_ff - asize_ff};
               wa_in[3] = rest + (csize_ff - asize_ff) - 17'd8;
               wd_in[3] = {15'd0, csize_ff - asize_ff};
               wn_in = 3'd4;
               p_in = rest;
               step_in = 5'd9;
               state_in = S_RDW;
            end else begin
               wa_in[0] = bp_ff - 17'd4; wd_in[0] = {15'd0, csize_ff | 17'd1};
               wa_in[1] = bp_ff + csize_ff - 17'd8; wd_in[1] = {15'd0, csize_ff | 17'd1};
               wn_in = 3'd2;
               cont_in = K_RESP;
               state_in = S_WRQ;
            end
            wi_in = '0;
         end
         S_RESP: begin
            if (!ovld_ff) begin
               ovld_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // unlink completion inside carve goes to tag writes
      if (state_ff == S_WRQ && wi_ff >= wn_ff && cont_ff == K_CARVE_W) begin
         state_in = S_CARVE1;
      end
      // merge after grow at run time: after push, carve the merged block
      if (state_ff == S_RDW2 && act_ff == ActAlloc && clr_ff[AddrW] &&
          step_ff != 5'd9) begin
         csize_in = size_ff;
         state_in = S_CARVE0;
         step_in = '0;
      end
      if (state_ff == S_RDW2 && act_ff == ActAlloc && step_ff == 5'd9) begin
         state_in = S_RESP;
      end
   end
endmodule

>>> rtl/efl_checker.sv
// efl_checker: port-level assertions for the heap allocator
// depends on efl_pkg; bound to explicit_free_list_heap_allocator
module efl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_payload_offset,
   input logic [1:0]  rsp_status
);
   import efl_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_offset))
      else $error("rsp beat dropped under stall");

   a_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != StDone |-> rsp_payload_offset == 16'd0)
      else $error("null status with nonzero offset");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status code");

   a_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload_offset[2:0] == 3'd0)
      else $error("unaligned payload offset");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");
endmodule

bind explicit_free_list_heap_allocator efl_checker u_efl_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_payload_offset(rsp_payload_offset), .rsp_status(rsp_status)
);

>>> dv/testbench.sv
// testbench: self-checking bench for explicit_free_list_heap_allocator
// drives allocate and free requests, predicts each response with a local heap model
// depends on efl_pkg and the allocator rtl
`timescale 1ns / 100ps

module testbench;
   import efl_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = ActAlloc;
   logic [15:0] req_request_bytes = '0;
   logic [15:0] req_block_offset = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_payload_offset;
   logic [1:0]  rsp_status;

   typedef struct packed {
      logic [15:0] offset;
      logic [1:0]  status;
   } alloc_result_type;

   typedef struct {
      logic        act;
      logic [15:0] bytes;
      logic [15:0] offset;
      logic        known;
      logic [15:0] exp_offset;
      logic [1:0]  exp_status;
   } stim_row_type;

   explicit_free_list_heap_allocator dut (.*);

   always #5 clock = ~clock;

   // heap model
   logic [31:0] heap_mem [HeapWords];
   logic [31:0] list_head;
   logic [31:0] brk;
   alloc_result_type results_q[$];
   logic [15:0] live_blocks[$];
   int errors = 0;
   int n_rsp = 0;
   int n_full = 0;
   int n_merge = 0;
   bit quiet_rx = 1'b0;
   bit hold_rx = 1'b0;
   longint cycles = 0;

   function automatic logic [31:0] hrd(logic [31:0] a);
      logic [31:0] i;
      i = a >> 2;
      return (i < HeapWords) ? heap_mem[i] : 32'd0;
   endfunction

   function automatic void hwr(logic [31:0] a, logic [31:0] v);
      logic [31:0] i;
      i = a >> 2;
      if (i < HeapWords) heap_mem[i] = v;
   endfunction

   function automatic logic [31:0] bsize(logic [31:0] bp);
      return hrd(bp - 4) & ~32'd7;
   endfunction

   function automatic logic [31:0] align_up(logic [31:0] x);
      return (x + AlignBytes - 1) / AlignBytes * AlignBytes;
   endfunction

   function automatic void push_free(logic [31:0] bp);
      hwr(bp, list_head);
      hwr(bp + 4, 0);
      if (list_head != 0) hwr(list_head + 4, bp);
      list_head = bp & 32'hffff;
   endfunction

   function automatic void unlink_free(logic [31:0] bp);
      logic [31:0] p, n;
      p = hrd(bp + 4) & 32'hffff;
      n = hrd(bp) & 32'hffff;
      if (p == 0) list_head = n;
      else hwr(p, n);
      if (n != 0) hwr(n + 4, p);
   endfunction

   function automatic logic [31:0] coalesce(logic [31:0] bp);
      logic [31:0] prv, nxt, pa, na, sz;
      prv = bp - (hrd(bp - 8) & ~32'd7);
      nxt = bp + bsize(bp);
      pa = hrd(bp - 8) & 1;
      na = hrd(nxt - 4) & 1;
      sz = bsize(bp);
      if (!(pa && na)) n_merge++;
      if (pa && !na) begin
         unlink_free(nxt);
         sz += bsize(nxt);
      end else if (!pa && na) begin
         unlink_free(prv);
         sz += bsize(prv);
         bp = prv;
      end else if (!pa && !na) begin
         unlink_free(prv);
         unlink_free(nxt);
         sz += bsize(prv) + bsize(nxt);
         bp = prv;
      end
      hwr(bp - 4, sz);
      hwr(bp + sz - 8, sz);
      push_free(bp);
      return bp;
   endfunction

   function automatic logic [31:0] grow_heap(logic [31:0] bytes);
      logic [31:0] sz, bp;
      sz = align_up(bytes);
      bp = brk;
      if (bp > HeapLimit || sz > HeapLimit - bp) return 0;
      hwr(bp - 4, sz);
      hwr(bp + sz - 8, sz);
      hwr(bp + sz - 4, 1);
      brk = bp + sz;
      return coalesce(bp);
   endfunction

   function automatic logic [31:0] search_free_list(logic [31:0] asize);
      logic [31:0] p;
      int n;
      p = list_head;
      n = 0;
      while (p != 0 && n < HeapWords) begin
         if (asize <= bsize(p)) return p;
         p = hrd(p) & 32'hffff;
         n++;
      end
      return 0;
   endfunction

   function automatic void place(logic [31:0] bp, logic [31:0] asize);
      logic [31:0] csize, rest;
      csize = bsize(bp);
      unlink_free(bp);
      if (csize >= asize && csize - asize >= MinBlock) begin
         rest = bp + asize;
         hwr(bp - 4, asize | 1);
         hwr(bp + asize - 8, asize | 1);
         hwr(rest - 4, csize - asize);
         hwr(rest + csize - asize - 8, csize - asize);
         push_free(rest);
      end else begin
         hwr(bp - 4, csize | 1);
         hwr(bp + csize - 8, csize | 1);
      end
   endfunction

   function automatic void heap_init();
      foreach (heap_mem[i]) heap_mem[i] = 0;
      hwr(4, 9);
      hwr(8, 9);
      hwr(12, 1);
      brk = 16;
      list_head = 0;
      void'(grow_heap(ChunkBytes / 4 * 4));
   endfunction

   function automatic alloc_result_type heap_request(logic act, logic [15:0] bytes,
                                                     logic [15:0] offset);
      alloc_result_type r;
      logic [31:0] asize, bp, ext, h, sz, off;
      r = '{offset: 16'd0, status: StDone};
      off = {16'd0, offset};
      if (act == ActAlloc) begin
         if (bytes == 0) begin
            r.status = StZero;
         end else begin
            asize = (bytes + 8 <= MinBlock) ? MinBlock : align_up(bytes + 8);
            bp = search_free_list(asize);
            if (bp == 0) begin
               ext = (asize > ChunkBytes) ? asize : ChunkBytes;
               bp = grow_heap(ext / 4 * 4);
            end
            if (bp == 0) begin
               r.status = StFull;
            end else begin
               place(bp, asize);
               r.offset = bp[15:0];
            end
         end
      end else begin
         h = hrd(off - 4);
         sz = h & ~32'd7;
         if (off >= 16 && off[2:0] == 0 && off < brk && h[0] && sz >= MinBlock &&
             sz <= brk - off && hrd(off + sz - 8) == h) begin
            hwr(off - 4, sz);
            hwr(off + sz - 8, sz);
            void'(coalesce(off));
         end
      end
      return r;
   endfunction

   // receiver side
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd3000000) begin
         $display("** explicit_free_list_heap_allocator: FAILED **");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         alloc_result_type e;
         if (results_q.size() == 0) begin
            $error("unexpected beat: payload_offset %0d status %0d",
                   rsp_payload_offset, rsp_status);
            errors++;
         end else begin
            e = results_q.pop_front();
            n_rsp++;
            if (e.status == StFull) n_full++;
            if (rsp_payload_offset !== e.offset) begin
               $error("payload_offset exp %0d got %0d", e.offset, rsp_payload_offset);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status);
               errors++;
            end
            if (e.status == StDone && e.offset != 0) live_blocks.push_back(e.offset);
         end
      end
      rsp_stall <= hold_rx ? 1'b1 : (quiet_rx ? 1'b0 : ($urandom_range(99) < 38));
   end

   // valid stays high into the next beat unless an idle cycle is drawn
   task automatic send_beat(logic act, logic [15:0] bytes, logic [15:0] offset,
                            bit gaps);
      if (gaps) begin
         while ($urandom_range(99) < 38) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_request_bytes <= bytes;
      req_block_offset <= offset;
      results_q.push_back(heap_request(act, bytes, offset));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      int k;
      k = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_q.size() != 0 && k < 2000000) begin
         @(posedge clock);
         k++;
      end
   endtask

   task automatic random_beat(bit gaps);
      int r, idx;
      logic [15:0] b;
      r = $urandom_range(99);
      if (r < 45) begin
         case ($urandom_range(9))
            0: b = 16'($urandom_range(65535));
            1: b = 16'($urandom_range(8192, 16384));
            2, 3: b = 16'($urandom_range(1, 16));
            default: b = 16'($urandom_range(1, 600));
         endcase
         send_beat(ActAlloc, b, 16'($urandom), gaps);
      end else if (r < 88 && live_blocks.size() != 0) begin
         idx = $urandom_range(live_blocks.size() - 1);
         b = live_blocks[idx];
         live_blocks.delete(idx);
         send_beat(ActFree, 16'($urandom), b, gaps);
      end else if (r < 94) begin
         send_beat(ActFree, 16'($urandom), 16'($urandom), gaps);
      end else begin
         send_beat(ActAlloc, 16'd0, 16'($urandom), gaps);
      end
   endtask

   stim_row_type rows[$];

   initial begin
      heap_init();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table: known rows are read straight off the heap layout after reset
      rows = '{
         '{ActAlloc, 16'd0,     16'd0,     1, 16'd0,  StZero},
         '{ActAlloc, 16'd1,     16'd0,     1, 16'd16, StDone},
         '{ActAlloc, 16'd16,    16'd0,     1, 16'd40, StDone},
         '{ActAlloc, 16'd17,    16'd0,     0, 16'd0,  StDone},
         '{ActAlloc, 16'hffff,  16'hffff,  1, 16'd0,  StFull},
         '{ActFree,  16'hffff,  16'd0,     1, 16'd0,  StDone},
         '{ActFree,  16'd0,     16'd20,    1, 16'd0,  StDone},
         '{ActFree,  16'd0,     16'hfff8,  1, 16'd0,  StDone},
         '{ActFree,  16'd0,     16'd40,    0, 16'd0,  StDone},
         '{ActFree,  16'd0,     16'd40,    1, 16'd0,  StDone},
         '{ActFree,  16'd0,     16'd16,    0, 16'd0,  StDone},
         '{ActAlloc, 16'd5000,  16'd0,     0, 16'd0,  StDone},
         '{ActAlloc, 16'd100,   16'd0,     0, 16'd0,  StDone},
         '{ActAlloc, 16'd200,   16'd0,     0, 16'd0,  StDone},
         '{ActAlloc, 16'd300,   16'd0,     0, 16'd0,  StDone},
         '{ActAlloc, 16'd60000, 16'd0,     0, 16'd0,  StDone},
         '{ActAlloc, 16'd40000, 16'd0,     0, 16'd0,  StDone},
         '{ActAlloc, 16'haaaa,  16'h5555,  0, 16'd0,  StDone},
         '{ActFree,  16'h5555,  16'haaa8,  0, 16'd0,  StDone}
      };
      foreach (rows[i]) begin
         alloc_result_type p;
         send_beat(rows[i].act, rows[i].bytes, rows[i].offset, 0);
         p = results_q[$];
         if (rows[i].known && (p.offset !== rows[i].exp_offset ||
                               p.status !== rows[i].exp_status)) begin
            $error("row %0d: payload_offset exp %0d got %0d, status exp %0d got %0d", i,
                   rows[i].exp_offset, p.offset, rows[i].exp_status, p.status);
            errors++;
         end
      end
      wait_drained();
      // live blocks are freed one at a time, newest first, each drained before the next
      while (live_blocks.size() != 0) begin
         send_beat(ActFree, 16'd0, live_blocks.pop_back(), 1);
         wait_drained();
      end

      for (int i = 0; i < 800; i++) begin
         if (i == 200) begin
            // long receiver hold-off while requests keep coming
            fork
               begin
                  hold_rx = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_rx = 1'b0;
               end
            join_none
         end
         if (i == 400) wait_drained();
         quiet_rx = (i >= 500 && i < 600);
         random_beat(!(i >= 500 && i < 600));
      end
      quiet_rx = 1'b0;
      wait_drained();
      repeat (200) @(posedge clock);
      $display("run covered %0d responses, %0d heap exhausted, %0d merges",
               n_rsp, n_full, n_merge);
      if (errors == 0 && results_q.size() == 0) begin
         $display("** explicit_free_list_heap_allocator: PASSED **");
      end else begin
         $display("** explicit_free_list_heap_allocator: FAILED **");
      end
      $finish;
   end
endmodule

>>> sim.f
rtl/efl_pkg.sv
rtl/explicit_free_list_heap_allocator.sv
rtl/efl_checker.sv
dv/testbench.sv
